FILE: hw/rtl/forward_obstacle_avoidance_monitor_macros.svh
// Assertion helpers shared by the monitor RTL.
`ifndef FORWARD_OBSTACLE_AVOIDANCE_MONITOR_MACROS_SVH
`define FORWARD_OBSTACLE_AVOIDANCE_MONITOR_MACROS_SVH

// A property that is checked only outside reset.
`define FOAM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A property that is also checked while reset is high.
`define FOAM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/foam_pkg.sv
`default_nettype none

package foam_pkg;

   // Reported monitor status.
   typedef enum logic [2:0] {
      STATUS_DISABLED   = 3'd0,
      STATUS_STANDBY    = 3'd1,
      STATUS_MONITORING = 3'd2,
      STATUS_THREAT     = 3'd3,
      STATUS_BLOCKING   = 3'd4
   } status_type;

   // Command issued on a trigger.
   typedef enum logic [1:0] {
      CMD_NONE     = 2'd0,
      CMD_FAILSAFE = 2'd1,
      CMD_LAND     = 2'd2,
      CMD_STOP     = 2'd3
   } command_type;

   // Flight-mode classes.
   localparam logic [2:0] MODE_OTHER   = 3'd0;
   localparam logic [2:0] MODE_AUTO    = 3'd1;
   localparam logic [2:0] MODE_LOITER  = 3'd2;
   localparam logic [2:0] MODE_POSHOLD = 3'd3;
   localparam logic [2:0] MODE_ALTHOLD = 3'd4;
   localparam logic [2:0] MODE_RTL     = 3'd5;
   localparam logic [2:0] MODE_LAND    = 3'd6;

   // Gate modes.
   localparam logic [1:0] GATE_OFF = 2'd0;
   localparam logic [1:0] GATE_ON  = 2'd1;

   // Height conditions.
   localparam logic [1:0] HEIGHT_NONE    = 2'd0;
   localparam logic [1:0] HEIGHT_HOME    = 2'd1;
   localparam logic [1:0] HEIGHT_TERRAIN = 2'd2;
   localparam logic [1:0] HEIGHT_NEVER   = 2'd3;

   // Configuration register indexes.
   localparam logic [2:0] CSR_ENABLE_MASK    = 3'd0;
   localparam logic [2:0] CSR_GATE_MODE      = 3'd1;
   localparam logic [2:0] CSR_HEIGHT_COND    = 3'd2;
   localparam logic [2:0] CSR_DIST_THRESHOLD = 3'd3;
   localparam logic [2:0] CSR_SAMPLE_COUNT   = 3'd4;
   localparam logic [2:0] CSR_HEIGHT_THRESH  = 3'd5;
   localparam logic [2:0] CSR_AUTO_ACTION    = 3'd6;
   localparam logic [2:0] CSR_MANUAL_ACTION  = 3'd7;

   localparam int unsigned CsrWidth = 19;

   // Fixed thresholds and action codes.
   localparam logic [11:0]        SwitchHighUs   = 12'd1500;
   localparam logic signed [13:0] StickDeadzone  = 14'sd100;
   localparam logic [2:0]         ManualStopCode = 3'd4;
   localparam logic [2:0]         MaxFsCode      = 3'd3;

   // One input item as held in the input register.
   typedef struct packed {
      logic               armed;
      logic               radio_failsafe;
      logic [11:0]        switch_pulse_us;
      logic [2:0]         mode_class;
      logic               landing_phase;
      logic               home_height_valid;
      logic signed [18:0] home_height_cm;
      logic               terrain_height_valid;
      logic signed [18:0] terrain_height_cm;
      logic               range_good;
      logic [15:0]        range_cm;
      logic signed [13:0] pitch_stick;
   } req_type;

endpackage

`default_nettype wire

FILE: hw/rtl/forward_obstacle_avoidance_monitor.sv
// Forward obstacle avoidance monitor. Each tick is one input transfer and gives exactly one
// result transfer. A tick passes through an input register and a result register, so its
// result is offered once the tick has been loaded into the result register. One tick is
// taken in every cycle while the result side keeps up; the debounce counter and the trip and
// lockout flags are updated in the same single pass that moves a tick from the input register
// to the result register. The user must see that configuration is written through the csr_
// port only while no tick is in flight; the block itself does not enforce this.
`default_nettype none

`include "forward_obstacle_avoidance_monitor_macros.svh"

module forward_obstacle_avoidance_monitor (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Configuration write port
   input  wire logic                                 csr_write_en,
   input  wire logic [2:0]                           csr_index,
   input  wire logic [foam_pkg::CsrWidth-1:0]        csr_wdata,
   // Input channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_armed,
   input  wire logic                                 req_radio_failsafe,
   input  wire logic [11:0]                          req_switch_pulse_us,
   input  wire logic [2:0]                           req_mode_class,
   input  wire logic                                 req_landing_phase,
   input  wire logic                                 req_home_height_valid,
   input  wire logic signed [18:0]                   req_home_height_cm,
   input  wire logic                                 req_terrain_height_valid,
   input  wire logic signed [18:0]                   req_terrain_height_cm,
   input  wire logic                                 req_range_good,
   input  wire logic [15:0]                          req_range_cm,
   input  wire logic signed [13:0]                   req_pitch_stick,
   // Result channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [2:0]                                rsp_status,
   output logic [1:0]                                rsp_command,
   output logic [1:0]                                rsp_failsafe_code,
   output logic                                      rsp_pitch_lockout,
   output logic                                      rsp_gate_active
);

   // Configuration registers
   logic [4:0]         enable_mask_ff;
   logic [1:0]         gate_mode_ff;
   logic [1:0]         height_cond_ff;
   logic [15:0]        dist_threshold_ff;
   logic [7:0]         sample_count_ff;
   logic signed [18:0] height_thresh_ff;
   logic [2:0]         auto_action_ff;
   logic [2:0]         manual_action_ff;

   // Pipeline registers
   logic              s1_valid_ff, s1_valid_in;
   foam_pkg::req_type s1_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_status_ff, rsp_status_in;
   logic [1:0]        rsp_command_ff, rsp_command_in;
   logic [1:0]        rsp_code_ff, rsp_code_in;
   logic              rsp_locked_ff;
   logic              rsp_active_ff, rsp_active_in;

   // Monitor state
   logic [7:0] near_count_ff, near_count_in;
   logic       tripped_ff, tripped_in;
   logic       lockout_ff, lockout_in;

   logic out_free, s1_fire, req_accept;
   logic mode_en, master_on, height_ok, range_near, stick_neutral;
   logic [7:0] count_up;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_mask_ff    <= '0;
         gate_mode_ff      <= '0;
         height_cond_ff    <= '0;
         dist_threshold_ff <= '0;
         sample_count_ff   <= '0;
         height_thresh_ff  <= '0;
         auto_action_ff    <= '0;
         manual_action_ff  <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            foam_pkg::CSR_ENABLE_MASK:    enable_mask_ff    <= csr_wdata[4:0];
            foam_pkg::CSR_GATE_MODE:      gate_mode_ff      <= csr_wdata[1:0];
            foam_pkg::CSR_HEIGHT_COND:    height_cond_ff    <= csr_wdata[1:0];
            foam_pkg::CSR_DIST_THRESHOLD: dist_threshold_ff <= csr_wdata[15:0];
            foam_pkg::CSR_SAMPLE_COUNT:   sample_count_ff   <= csr_wdata[7:0];
            foam_pkg::CSR_HEIGHT_THRESH:  height_thresh_ff  <= signed'(csr_wdata[18:0]);
            foam_pkg::CSR_AUTO_ACTION:    auto_action_ff    <= csr_wdata[2:0];
            foam_pkg::CSR_MANUAL_ACTION:  manual_action_ff  <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // Handshake: the result register frees up when empty or when its transfer completes.
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign s1_fire     = s1_valid_ff && out_free;
   assign req_stall   = s1_valid_ff && !out_free;
   assign req_accept  = req_valid && !req_stall;
   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_fire);
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && rsp_stall);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_accept) begin
         s1_ff.armed                <= req_armed;
         s1_ff.radio_failsafe       <= req_radio_failsafe;
         s1_ff.switch_pulse_us      <= req_switch_pulse_us;
         s1_ff.mode_class           <= req_mode_class;
         s1_ff.landing_phase        <= req_landing_phase;
         s1_ff.home_height_valid    <= req_home_height_valid;
         s1_ff.home_height_cm       <= req_home_height_cm;
         s1_ff.terrain_height_valid <= req_terrain_height_valid;
         s1_ff.terrain_height_cm    <= req_terrain_height_cm;
         s1_ff.range_good           <= req_range_good;
         s1_ff.range_cm             <= req_range_cm;
         s1_ff.pitch_stick          <= req_pitch_stick;
      end
   end

   // Mode-group enable for the current flight mode.
   always_comb begin
      unique case (s1_ff.mode_class)
         foam_pkg::MODE_AUTO,
         foam_pkg::MODE_RTL:     mode_en = enable_mask_ff[0];
         foam_pkg::MODE_LOITER:  mode_en = enable_mask_ff[1];
         foam_pkg::MODE_POSHOLD: mode_en = enable_mask_ff[2];
         foam_pkg::MODE_ALTHOLD: mode_en = enable_mask_ff[3];
         default:                mode_en = 1'b0;
      endcase
   end

   // Master gate; any mode above plain on needs the switch high and the radio link up.
   always_comb begin
      priority if (gate_mode_ff == foam_pkg::GATE_OFF) begin
         master_on = 1'b0;
      end else if (gate_mode_ff == foam_pkg::GATE_ON) begin
         master_on = 1'b1;
      end else begin
         master_on = !s1_ff.radio_failsafe && (s1_ff.switch_pulse_us > foam_pkg::SwitchHighUs);
      end
   end

   // Height gate.
   always_comb begin
      unique case (height_cond_ff)
         foam_pkg::HEIGHT_NONE:    height_ok = 1'b1;
         foam_pkg::HEIGHT_HOME:    height_ok = s1_ff.home_height_valid &&
                                      (s1_ff.home_height_cm >= height_thresh_ff);
         foam_pkg::HEIGHT_TERRAIN: height_ok = s1_ff.terrain_height_valid &&
                                      (s1_ff.terrain_height_cm >= height_thresh_ff);
         foam_pkg::HEIGHT_NEVER:   height_ok = 1'b0;
         default:                  height_ok = 1'b0;
      endcase
   end

   assign range_near    = s1_ff.range_good && (s1_ff.range_cm != 16'd0) &&
                          (s1_ff.range_cm < dist_threshold_ff);
   assign stick_neutral = (s1_ff.pitch_stick > -foam_pkg::StickDeadzone) &&
                          (s1_ff.pitch_stick < foam_pkg::StickDeadzone);
   assign count_up      = (near_count_ff < sample_count_ff) ? near_count_ff + 8'd1
                                                            : near_count_ff;

   // Status, taken from the state left by the previous tick.
   always_comb begin
      priority if ((enable_mask_ff == 5'd0) || !master_on) begin
         rsp_status_in = foam_pkg::STATUS_DISABLED;
      end else if (tripped_ff || lockout_ff) begin
         rsp_status_in = foam_pkg::STATUS_BLOCKING;
      end else if (!height_ok || !mode_en || !s1_ff.range_good) begin
         rsp_status_in = foam_pkg::STATUS_STANDBY;
      end else if (range_near) begin
         rsp_status_in = foam_pkg::STATUS_THREAT;
      end else begin
         rsp_status_in = foam_pkg::STATUS_MONITORING;
      end
   end

   // Gates, debounce counter, trigger and stick unlock.
   always_comb begin
      near_count_in  = near_count_ff;
      tripped_in     = tripped_ff;
      lockout_in     = lockout_ff;
      rsp_command_in = foam_pkg::CMD_NONE;
      rsp_code_in    = 2'd0;
      rsp_active_in  = 1'b0;
      if (enable_mask_ff == 5'd0) begin
         // Block disabled: state is left alone.
      end else if (!s1_ff.armed) begin
         near_count_in = 8'd0;
         tripped_in    = 1'b0;
         lockout_in    = 1'b0;
      end else if (!(master_on && height_ok)) begin
         near_count_in = 8'd0;
         tripped_in    = 1'b0;
         lockout_in    = 1'b0;
      end else if (!mode_en) begin
         rsp_active_in = 1'b1;
         near_count_in = 8'd0;
         if (lockout_ff) begin
            lockout_in = 1'b0;
            tripped_in = 1'b0;
         end
      end else begin
         rsp_active_in = 1'b1;
         // Release the lockout once the stick is centred and the count has drained.
         if (lockout_ff && stick_neutral && (near_count_ff == 8'd0)) begin
            lockout_in = 1'b0;
            tripped_in = 1'b0;
         end
         if (range_near) begin
            near_count_in = count_up;
            if ((count_up >= sample_count_ff) && !tripped_in) begin
               tripped_in = 1'b1;
               priority if (s1_ff.landing_phase) begin
                  // Landing continues without a command.
               end else if (s1_ff.mode_class == foam_pkg::MODE_RTL) begin
                  rsp_command_in = foam_pkg::CMD_LAND;
               end else if (s1_ff.mode_class == foam_pkg::MODE_LAND) begin
                  // Already in land mode.
               end else if (s1_ff.mode_class == foam_pkg::MODE_AUTO) begin
                  rsp_command_in = foam_pkg::CMD_FAILSAFE;
                  rsp_code_in    = (auto_action_ff <= foam_pkg::MaxFsCode) ?
                                   auto_action_ff[1:0] : 2'd0;
               end else if (manual_action_ff == foam_pkg::ManualStopCode) begin
                  rsp_command_in = foam_pkg::CMD_STOP;
                  lockout_in     = 1'b1;
               end else begin
                  rsp_command_in = foam_pkg::CMD_FAILSAFE;
                  rsp_code_in    = (manual_action_ff <= foam_pkg::MaxFsCode) ?
                                   manual_action_ff[1:0] : 2'd0;
               end
            end
         end else begin
            if (near_count_ff != 8'd0) begin
               near_count_in = near_count_ff - 8'd1;
            end
            if (tripped_in && (near_count_in == 8'd0) && !lockout_in) begin
               tripped_in = 1'b0;
            end
         end
      end
   end

   // State and result register, both loaded as a tick leaves the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         near_count_ff <= '0;
         tripped_ff    <= 1'b0;
         lockout_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            near_count_ff <= near_count_in;
            tripped_ff    <= tripped_in;
            lockout_ff    <= lockout_in;
         end
      end
      if (s1_fire) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_command_ff <= rsp_command_in;
         rsp_code_ff    <= rsp_code_in;
         rsp_locked_ff  <= lockout_in;
         rsp_active_ff  <= rsp_active_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_command       = rsp_command_ff;
   assign rsp_failsafe_code = rsp_code_ff;
   assign rsp_pitch_lockout = rsp_locked_ff;
   assign rsp_gate_active   = rsp_active_ff;

   // Checks on the monitor state and the result register.
   `FOAM_ASSERT(a_lockout_needs_trip, clock, reset, lockout_ff |-> tripped_ff, "lockout without trip")
   `FOAM_ASSERT(a_stop_locks, clock, reset, (rsp_valid_ff && (rsp_command_ff == foam_pkg::CMD_STOP)) |-> rsp_locked_ff, "stop command without stick lockout")
   `FOAM_ASSERT(a_code_with_failsafe, clock, reset, (rsp_valid_ff && (rsp_code_ff != 2'd0)) |-> (rsp_command_ff == foam_pkg::CMD_FAILSAFE), "failsafe code without failsafe command")
   `FOAM_ASSERT(a_cmd_needs_gate, clock, reset, (rsp_valid_ff && !rsp_active_ff) |-> (rsp_command_ff == foam_pkg::CMD_NONE), "command issued with gate inactive")
   `FOAM_ASSERT_ALWAYS(a_reset_empties, clock, $past(reset) |-> (!s1_valid_ff && !rsp_valid_ff), "pipeline not empty after reset")

endmodule

`default_nettype wire
